### hdl/trc_pkg.sv
`default_nettype none

package trc_pkg;

    localparam int DEPTH      = 512;
    localparam int MAX_BYTES  = 40;
    localparam int SLOT_W     = $clog2(DEPTH);
    localparam int COUNT_W    = SLOT_W + 1;
    localparam int LEN_W      = 6;
    localparam int BYTE_WORDS = DEPTH * MAX_BYTES;
    localparam int BADDR_W    = $clog2(BYTE_WORDS);

    typedef enum logic [2:0] {
        OP_HEADER  = 3'd0,
        OP_BYTE    = 3'd1,
        OP_ENABLE  = 3'd2,
        OP_DISABLE = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_EXPORT  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_BYTE   = 2'd2
    } kind_t;

    typedef struct packed {
        op_t              op;
        logic [2:0]       direction;
        logic [31:0]      tick;
        logic [LEN_W-1:0] length;
        logic [7:0]       byte_value;
    } item_t;

    typedef struct packed {
        kind_t            kind;
        logic [31:0]      sequence_res;
        logic [2:0]       source_tag;
        logic [31:0]      stamp;
        logic [LEN_W-1:0] stored_length;
        logic             overwrite_seen;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] byte_position;
        logic             last;
        logic             drained;
    } result_t;

endpackage

`default_nettype wire

### hdl/overwriting_trace_recorder.sv
`default_nettype none

// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_stall   action, direction, tick, frame_length, byte_value
// output   out        out_valid / out_stall kind, sequence_res, source_tag, stamp,
//                                           stored_length, overwrite_seen, data_byte,
//                                           byte_position, last, drained
//
// Logging items (header, byte, enable, disable, clear) are handled in the back end's idle state.
// An export holds the back end for a header read, the header transfer, then one byte-memory
// read per byte; an export of an empty store sends only the empty marker from the idle state.
// A two-entry queue lets the input side keep taking transfers while an export runs.
// Asynchronous active-low reset; the stores are not cleared and need no sweep.
// Output stalls hold exports in the back end; a full queue raises in_stall.

module overwriting_trace_recorder
    import trc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  direction,
    input  logic [31:0] tick,
    input  logic [7:0]  frame_length,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [31:0] sequence_res,
    output logic [2:0]  source_tag,
    output logic [31:0] stamp,
    output logic [5:0]  stored_length,
    output logic        overwrite_seen,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_position,
    output logic        last,
    output logic        drained
);

    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t res;

    trc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .direction    (direction),
        .tick         (tick),
        .frame_length (frame_length),
        .byte_value   (byte_value),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    trc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    assign kind           = res.kind;
    assign sequence_res   = res.sequence_res;
    assign source_tag     = res.source_tag;
    assign stamp          = res.stamp;
    assign stored_length  = res.stored_length;
    assign overwrite_seen = res.overwrite_seen;
    assign data_byte      = res.data_byte;
    assign byte_position  = res.byte_position;
    assign last           = res.last;
    assign drained        = res.drained;

`ifndef SYNTHESIS
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_EMPTY |-> last && !drained)
        else $error("empty marker not a lone final transfer");

    a_byte_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_BYTE |-> byte_position < stored_length)
        else $error("byte position beyond stored length");

    a_follow_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> !out_valid || kind == KIND_BYTE)
        else $error("export ended before its last byte");

    a_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

### hdl/trc_ram.sv
`default_nettype none

module trc_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(WORDS)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(WORDS)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [WORDS];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### hdl/trc_front.sv
`default_nettype none

module trc_front
    import trc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  direction,
    input  logic [31:0] tick,
    input  logic [7:0]  frame_length,
    input  logic [7:0]  byte_value,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    localparam logic [1:0] Q_DEPTH = 2'd2;

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      item_in;
    logic       known;
    logic       push;

    // actions 6 and 7 are taken off the link and dropped here
    always_comb
    begin
        known             = (action <= OP_EXPORT);
        item_in.op        = known ? op_t'(action) : OP_DISABLE;
        item_in.direction = direction;
        item_in.tick      = tick;
        item_in.length    = (frame_length > 8'(MAX_BYTES)) ? LEN_W'(MAX_BYTES)
                                                          : frame_length[LEN_W-1:0];
        item_in.byte_value = byte_value;
    end

    assign in_stall = (cnt_reg == Q_DEPTH);
    assign push     = in_valid && !in_stall && known;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

### hdl/trc_back.sv
`default_nettype none

module trc_back
    import trc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  item_t   q_item,
    output logic    q_pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t res
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_BYTE
    } state_t;

    typedef struct packed {
        logic [2:0]       dir;
        logic [31:0]      stamp;
        logic [LEN_W-1:0] len;
    } hdr_t;

    localparam logic [BADDR_W-1:0] MAX_BYTES_A = BADDR_W'(MAX_BYTES);

    state_t             state_reg, state_next;
    logic [SLOT_W-1:0]  write_index_reg, write_index_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        seq_reg, seq_next;
    logic [31:0]        start_tick_reg, start_tick_next;
    logic               recording_reg, recording_next;
    logic               ovf_reg, ovf_next;
    logic               open_reg, open_next;
    logic [LEN_W-1:0]   fill_reg, fill_next;
    logic [LEN_W-1:0]   open_len_reg, open_len_next;
    logic [SLOT_W-1:0]  open_slot_reg, open_slot_next;
    logic [BADDR_W-1:0] open_base_reg, open_base_next;
    logic [SLOT_W-1:0]  exp_slot_reg, exp_slot_next;
    logic [31:0]        exp_seq_reg, exp_seq_next;
    logic               exp_ovr_reg, exp_ovr_next;
    logic               exp_drained_reg, exp_drained_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               out_free;
    logic [COUNT_W-1:0] diff;
    logic [COUNT_W-1:0] diff_wrap;
    logic [SLOT_W-1:0]  old_slot;
    logic [SLOT_W-1:0]  wi_inc;

    logic               hdr_we, hdr_re;
    hdr_t               hdr_wdata, hdr_rdata;
    logic               byte_we, byte_re;
    logic [BADDR_W-1:0] byte_waddr, byte_raddr;
    logic [7:0]         byte_rdata;
    logic [BADDR_W-1:0] exp_base;

    assign out_free  = !out_valid_reg || !out_stall;
    assign q_pop     = q_valid && (state_reg == S_IDLE)
                       && (q_item.op != OP_EXPORT || out_free);
    assign out_valid = out_valid_reg;
    assign res       = out_reg;

    // oldest slot: write index minus count, modulo the ring depth
    assign diff      = {1'b0, write_index_reg} - count_reg;
    assign diff_wrap = diff + COUNT_W'(DEPTH);
    assign old_slot  = ({1'b0, write_index_reg} >= count_reg) ? diff[SLOT_W-1:0]
                                                              : diff_wrap[SLOT_W-1:0];
    assign wi_inc    = (write_index_reg == SLOT_W'(DEPTH - 1)) ? '0 : write_index_reg + 1'b1;
    assign exp_base  = BADDR_W'(exp_slot_reg) * MAX_BYTES_A;

    assign hdr_wdata.dir   = q_item.direction;
    assign hdr_wdata.stamp = q_item.tick - start_tick_reg;
    assign hdr_wdata.len   = q_item.length;
    assign byte_waddr      = open_base_reg + BADDR_W'(fill_reg);

    always_comb
    begin
        state_next       = state_reg;
        write_index_next = write_index_reg;
        count_next       = count_reg;
        seq_next         = seq_reg;
        start_tick_next  = start_tick_reg;
        recording_next   = recording_reg;
        ovf_next         = ovf_reg;
        open_next        = open_reg;
        fill_next        = fill_reg;
        open_len_next    = open_len_reg;
        open_slot_next   = open_slot_reg;
        open_base_next   = open_base_reg;
        exp_slot_next    = exp_slot_reg;
        exp_seq_next     = exp_seq_reg;
        exp_ovr_next     = exp_ovr_reg;
        exp_drained_next = exp_drained_reg;
        pos_next         = pos_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_next         = out_reg;
        hdr_we           = 1'b0;
        hdr_re           = 1'b0;
        byte_we          = 1'b0;
        byte_re          = 1'b0;
        byte_raddr       = exp_base;

        case (state_reg)
            S_IDLE:
            begin
                if (q_pop)
                begin
                    case (q_item.op)
                        OP_HEADER:
                        begin
                            if (recording_reg)
                            begin
                                hdr_we           = 1'b1;
                                open_len_next    = q_item.length;
                                open_slot_next   = write_index_reg;
                                open_base_next   = BADDR_W'(write_index_reg) * MAX_BYTES_A;
                                write_index_next = wi_inc;
                                seq_next         = seq_reg + 32'd1;
                                if (count_reg < COUNT_W'(DEPTH))
                                begin
                                    count_next = count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                                open_next = 1'b1;
                                fill_next = '0;
                            end
                            else
                            begin
                                open_next = 1'b0;
                            end
                        end
                        OP_BYTE:
                        begin
                            if (open_reg && fill_reg < open_len_reg)
                            begin
                                byte_we   = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_ENABLE:
                        begin
                            write_index_next = '0;
                            count_next       = '0;
                            ovf_next         = 1'b0;
                            open_next        = 1'b0;
                            fill_next        = '0;
                            seq_next         = '0;
                            recording_next   = 1'b1;
                            start_tick_next  = q_item.tick;
                        end
                        OP_DISABLE:
                        begin
                            recording_next = 1'b0;
                        end
                        OP_CLEAR:
                        begin
                            write_index_next = '0;
                            count_next       = '0;
                            ovf_next         = 1'b0;
                            open_next        = 1'b0;
                            fill_next        = '0;
                        end
                        OP_EXPORT:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next         = 1'b1;
                                out_next               = '0;
                                out_next.kind          = KIND_EMPTY;
                                out_next.overwrite_seen = ovf_reg;
                                out_next.last          = 1'b1;
                            end
                            else
                            begin
                                hdr_re           = 1'b1;
                                exp_slot_next    = old_slot;
                                exp_seq_next     = seq_reg - 32'(count_reg) + 32'd1;
                                exp_ovr_next     = ovf_reg;
                                exp_drained_next = (count_reg == COUNT_W'(1));
                                if (count_reg == COUNT_W'(1))
                                begin
                                    ovf_next = 1'b0;
                                end
                                if (open_reg && old_slot == open_slot_reg)
                                begin
                                    open_next = 1'b0;
                                end
                                count_next = count_reg - 1'b1;
                                state_next = S_HDR;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.kind           = KIND_HEADER;
                    out_next.sequence_res   = exp_seq_reg;
                    out_next.source_tag     = hdr_rdata.dir;
                    out_next.stamp          = hdr_rdata.stamp;
                    out_next.stored_length  = hdr_rdata.len;
                    out_next.overwrite_seen = exp_ovr_reg;
                    out_next.data_byte      = '0;
                    out_next.byte_position  = '0;
                    out_next.last           = (hdr_rdata.len == '0);
                    out_next.drained        = exp_drained_reg;
                    pos_next                = '0;
                    if (hdr_rdata.len == '0)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        byte_re    = 1'b1;
                        byte_raddr = exp_base;
                        state_next = S_BYTE;
                    end
                end
            end
            S_BYTE:
            begin
                // read data holds until the next read, so a stall just waits
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.kind          = KIND_BYTE;
                    out_next.data_byte     = byte_rdata;
                    out_next.byte_position = pos_reg;
                    out_next.last          = (pos_reg + 1'b1 == hdr_rdata.len);
                    if (pos_reg + 1'b1 == hdr_rdata.len)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        byte_re    = 1'b1;
                        byte_raddr = exp_base + BADDR_W'(pos_reg + 1'b1);
                        pos_next   = pos_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            write_index_reg <= '0;
            count_reg       <= '0;
            seq_reg         <= '0;
            start_tick_reg  <= '0;
            recording_reg   <= 1'b0;
            ovf_reg         <= 1'b0;
            open_reg        <= 1'b0;
            fill_reg        <= '0;
            open_len_reg    <= '0;
            open_slot_reg   <= '0;
            open_base_reg   <= '0;
            exp_slot_reg    <= '0;
            exp_seq_reg     <= '0;
            exp_ovr_reg     <= 1'b0;
            exp_drained_reg <= 1'b0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            write_index_reg <= write_index_next;
            count_reg       <= count_next;
            seq_reg         <= seq_next;
            start_tick_reg  <= start_tick_next;
            recording_reg   <= recording_next;
            ovf_reg         <= ovf_next;
            open_reg        <= open_next;
            fill_reg        <= fill_next;
            open_len_reg    <= open_len_next;
            open_slot_reg   <= open_slot_next;
            open_base_reg   <= open_base_next;
            exp_slot_reg    <= exp_slot_next;
            exp_seq_reg     <= exp_seq_next;
            exp_ovr_reg     <= exp_ovr_next;
            exp_drained_reg <= exp_drained_next;
            pos_reg         <= pos_next;
            out_valid_reg   <= out_valid_next;
            out_reg         <= out_next;
        end
    end

    trc_ram #(
        .WIDTH ($bits(hdr_t)),
        .WORDS (DEPTH)
    ) u_hdr_ram (
        .clk     (clk),
        .wr_en   (hdr_we),
        .wr_addr (write_index_reg),
        .wr_data (hdr_wdata),
        .rd_en   (hdr_re),
        .rd_addr (old_slot),
        .rd_data (hdr_rdata)
    );

    trc_ram #(
        .WIDTH (8),
        .WORDS (BYTE_WORDS)
    ) u_byte_ram (
        .clk     (clk),
        .wr_en   (byte_we),
        .wr_addr (byte_waddr),
        .wr_data (q_item.byte_value),
        .rd_en   (byte_re),
        .rd_addr (byte_raddr),
        .rd_data (byte_rdata)
    );

endmodule

`default_nettype wire

### bench/trace_export_checker.sv
`timescale 1ns / 1ps

module trace_export_checker
    import trc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [2:0]  action,
    input  logic [2:0]  direction,
    input  logic [31:0] tick,
    input  logic [7:0]  frame_length,
    input  logic [7:0]  byte_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] sequence_res,
    input  logic [2:0]  source_tag,
    input  logic [31:0] stamp,
    input  logic [5:0]  stored_length,
    input  logic        overwrite_seen,
    input  logic [7:0]  data_byte,
    input  logic [5:0]  byte_position,
    input  logic        last,
    input  logic        drained,
    output int          mismatches,
    output int          outstanding
);

    // Predicted recorder state
    logic [2:0]         tag_mem   [DEPTH];
    logic [31:0]        stamp_mem [DEPTH];
    logic [LEN_W-1:0]   len_mem   [DEPTH];
    logic [7:0]         data_mem  [BYTE_WORDS];
    logic [SLOT_W-1:0]  wr_slot;
    logic [COUNT_W-1:0] held;
    logic [31:0]        seq_count;
    logic [31:0]        t0;
    logic               armed;
    logic               wrapped;
    logic               open_rec;
    logic [LEN_W-1:0]   fill;

    result_t            export_queue [$];
    result_t            want;

    task automatic forget_records();
        wr_slot  = '0;
        held     = '0;
        wrapped  = 1'b0;
        open_rec = 1'b0;
        fill     = '0;
    endtask

    task automatic predict_transfer();
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] tail;
        logic [LEN_W-1:0]  n;
        result_t           r;
        tail = wr_slot - 1'b1;
        case (action)
            OP_HEADER:
            begin
                if (!armed)
                    open_rec = 1'b0;
                else
                begin
                    tag_mem[wr_slot]   = direction;
                    stamp_mem[wr_slot] = tick - t0;
                    len_mem[wr_slot]   = (frame_length > MAX_BYTES) ? LEN_W'(MAX_BYTES)
                                                                    : LEN_W'(frame_length);
                    wr_slot   = wr_slot + 1'b1;
                    seq_count = seq_count + 32'd1;
                    if (held < DEPTH)
                        held = held + 1'b1;
                    else
                        wrapped = 1'b1;
                    open_rec = 1'b1;
                    fill     = '0;
                end
            end
            OP_BYTE:
            begin
                if (open_rec && fill < len_mem[tail])
                begin
                    data_mem[int'(tail) * MAX_BYTES + int'(fill)] = byte_value;
                    fill = fill + 1'b1;
                end
            end
            OP_ENABLE:
            begin
                forget_records();
                seq_count = '0;
                armed     = 1'b1;
                t0        = tick;
            end
            OP_DISABLE:
                armed = 1'b0;
            OP_CLEAR:
                forget_records();
            OP_EXPORT:
            begin
                r = '0;
                r.overwrite_seen = wrapped;
                if (held == 0)
                begin
                    r.kind = KIND_EMPTY;
                    r.last = 1'b1;
                    export_queue.push_back(r);
                end
                else
                begin
                    // held of DEPTH folds to zero here, which points at the write slot
                    slot = wr_slot - held[SLOT_W-1:0];
                    n    = len_mem[slot];
                    r.kind          = KIND_HEADER;
                    r.sequence_res  = seq_count - 32'(held) + 32'd1;
                    r.source_tag    = tag_mem[slot];
                    r.stamp         = stamp_mem[slot];
                    r.stored_length = n;
                    if (open_rec && slot == tail)
                        open_rec = 1'b0;
                    held = held - 1'b1;
                    r.drained = (held == 0);
                    if (held == 0)
                        wrapped = 1'b0;
                    r.last = (n == 0);
                    export_queue.push_back(r);
                    for (int i = 0; i < int'(n); i++)
                    begin
                        r.kind          = KIND_BYTE;
                        r.data_byte     = data_mem[int'(slot) * MAX_BYTES + i];
                        r.byte_position = LEN_W'(i);
                        r.last          = (i + 1 == int'(n));
                        export_queue.push_back(r);
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got_val);
        if (got_val !== exp_val)
        begin
            mismatches++;
            $display("%0t %s: expected %0h, got %0h", $time, name, exp_val, got_val);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forget_records();
            seq_count  = '0;
            t0         = '0;
            armed      = 1'b0;
            mismatches = 0;
            export_queue.delete();
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (export_queue.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result transfer: expected none, got kind %0d",
                             $time, kind);
                end
                else
                begin
                    want = export_queue.pop_front();
                    check_field("kind", 32'(want.kind), 32'(kind));
                    check_field("sequence_res", want.sequence_res, sequence_res);
                    check_field("source_tag", 32'(want.source_tag), 32'(source_tag));
                    check_field("stamp", want.stamp, stamp);
                    check_field("stored_length", 32'(want.stored_length),
                                32'(stored_length));
                    check_field("overwrite_seen", 32'(want.overwrite_seen),
                                32'(overwrite_seen));
                    check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
                    check_field("byte_position", 32'(want.byte_position),
                                32'(byte_position));
                    check_field("last", 32'(want.last), 32'(last));
                    check_field("drained", 32'(want.drained), 32'(drained));
                end
            end
            if (in_valid && !in_stall)
                predict_transfer();
            outstanding <= export_queue.size();
        end
    end

endmodule

### bench/tb_overwriting_trace_recorder.sv
`timescale 1ns / 1ps

module tb_overwriting_trace_recorder;
    import trc_pkg::*;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam int RANDOM_ITEMS = 410;
    localparam int FLOOD        = DEPTH + 3;
    localparam int LIMIT        = 400000;
    localparam int SETTLE       = 100;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [2:0]  direction;
    logic [31:0] tick;
    logic [7:0]  frame_length;
    logic [7:0]  byte_value;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [31:0] sequence_res;
    logic [2:0]  source_tag;
    logic [31:0] stamp;
    logic [5:0]  stored_length;
    logic        overwrite_seen;
    logic [7:0]  data_byte;
    logic [5:0]  byte_position;
    logic        last;
    logic        drained;
    int          mismatches;
    int          outstanding;

    logic        calm;
    int          cycles = 0;
    int          effective;

    // Light shadow of the ring, so that no export reads a byte slot never written and effective transfers are counted
    logic              sh_armed;
    logic [SLOT_W-1:0] sh_wr;
    int                sh_held;
    logic              sh_open;
    int                sh_fill;
    int                sh_len    [DEPTH];
    int                sh_filled [DEPTH];

    overwriting_trace_recorder DUT (.*);

    trace_export_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 22);

    function automatic logic [SLOT_W-1:0] oldest_slot();
        return sh_wr - SLOT_W'(sh_held);
    endfunction

    // Returns 0 for spare actions, headers while not recording and dropped bytes; 1 otherwise
    function automatic bit track(input logic [2:0] op, input logic [7:0] flen);
        logic [SLOT_W-1:0] tail;
        tail = sh_wr - 1'b1;
        case (op)
            OP_HEADER:
            begin
                if (!sh_armed)
                begin
                    sh_open = 1'b0;
                    return 1'b0;
                end
                sh_len[sh_wr] = (flen > MAX_BYTES) ? MAX_BYTES : int'(flen);
                sh_wr = sh_wr + 1'b1;
                if (sh_held < DEPTH)
                    sh_held++;
                sh_open = 1'b1;
                sh_fill = 0;
            end
            OP_BYTE:
            begin
                if (!(sh_open && sh_fill < sh_len[tail]))
                    return 1'b0;
                sh_fill++;
                if (sh_fill > sh_filled[tail])
                    sh_filled[tail] = sh_fill;
            end
            OP_ENABLE, OP_CLEAR:
            begin
                if (op == OP_ENABLE)
                    sh_armed = 1'b1;
                sh_wr   = '0;
                sh_held = 0;
                sh_open = 1'b0;
            end
            OP_DISABLE:
                sh_armed = 1'b0;
            OP_EXPORT:
            begin
                if (sh_held != 0)
                begin
                    if (sh_open && oldest_slot() == tail)
                        sh_open = 1'b0;
                    sh_held--;
                end
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    task automatic send(input logic [2:0] op, input logic [2:0] dir, input logic [31:0] tk,
                        input logic [7:0] flen, input logic [7:0] bval);
        while (!calm && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= op;
        direction    <= dir;
        tick         <= tk;
        frame_length <= flen;
        byte_value   <= bval;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (track(op, flen))
            effective++;
    endtask

    task automatic act(input logic [2:0] op);
        send(op, 3'($urandom_range(7)), $urandom, 8'($urandom_range(255)),
             8'($urandom_range(255)));
    endtask

    // Header followed by every byte it keeps; optionally a disable part-way through
    task automatic record(input logic [7:0] flen, input bit stop_mid);
        int n;
        n = (flen > MAX_BYTES) ? MAX_BYTES : int'(flen);
        send(OP_HEADER, 3'($urandom_range(7)), $urandom, flen, 8'($urandom_range(255)));
        for (int i = 0; i < n; i++)
        begin
            if (stop_mid && i == n / 2)
                act(OP_DISABLE);
            act(OP_BYTE);
        end
    endtask

    // Export only when every byte of the oldest record has been written at some point
    task automatic pop_oldest();
        logic [SLOT_W-1:0] slot;
        slot = oldest_slot();
        if (sh_held == 0 || sh_filled[slot] >= sh_len[slot])
            act(OP_EXPORT);
        else
            act(OP_CLEAR);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 8'($urandom_range(8));
        if (r < 85)
            return 8'($urandom_range(40, 9));
        return 8'($urandom_range(255, 41));
    endfunction

    initial
    begin
        int         goal;
        int         pick;
        int         k;
        bit         paused;
        logic [7:0] flen;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = OP_HEADER;
        direction    = '0;
        tick         = '0;
        frame_length = '0;
        byte_value   = '0;
        calm         = 1'b0;
        effective    = 0;
        paused       = 1'b0;
        sh_armed     = 1'b0;
        sh_wr        = '0;
        sh_held      = 0;
        sh_open      = 1'b0;
        sh_fill      = 0;
        foreach (sh_len[i])
        begin
            sh_len[i]    = 0;
            sh_filled[i] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed
        send(OP_EXPORT, 3'd7, 32'hFFFF_FFFF, 8'hFF, 8'hFF);     // empty marker
        send(OP_HEADER, 3'd5, 32'h1234_5678, 8'd3, 8'h00);      // not recording
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'hFF);                 // nothing open
        send(OP_SPARE_A, 3'd1, 32'h0, 8'd0, 8'h00);
        send(OP_SPARE_B, 3'd2, 32'h0, 8'd0, 8'h00);
        send(OP_ENABLE, 3'd0, 32'hFFFF_FFF0, 8'd0, 8'h00);
        send(OP_HEADER, 3'd7, 32'h0000_0005, 8'd3, 8'h00);      // stamp wraps past zero
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'hFF);
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'hA5);
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'h5A);                 // past stored length
        send(OP_HEADER, 3'd0, 32'hFFFF_FFFF, 8'd0, 8'h00);
        send(OP_DISABLE, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_HEADER, 3'd4, 32'h0, 8'd255, 8'h00);             // ignored, closes record
        send(OP_EXPORT, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_EXPORT, 3'd0, 32'h0, 8'd0, 8'h00);               // drains the store
        send(OP_EXPORT, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_ENABLE, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_HEADER, 3'd4, 32'h0, 8'd2, 8'h00);
        send(OP_DISABLE, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'h81);                 // still open after disable
        send(OP_BYTE, 3'd0, 32'h0, 8'd0, 8'h7E);
        send(OP_CLEAR, 3'd0, 32'h0, 8'd0, 8'h00);
        send(OP_EXPORT, 3'd0, 32'h0, 8'd0, 8'h00);

        // Random
        goal = effective + RANDOM_ITEMS;
        while (effective < goal)
        begin
            calm <= (effective >= goal - RANDOM_ITEMS + 150 && effective < goal - 170);
            if (!paused && effective >= goal - 110)
            begin
                wait_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                if (!sh_armed)
                    act(OP_ENABLE);
                record(pick_length(), $urandom_range(7) == 0);
                if ($urandom_range(9) == 0)
                    act(OP_BYTE);
            end
            else if (pick < 75)
                pop_oldest();
            else if (pick < 90)
            begin
                case ($urandom_range(6))
                    0: act($urandom_range(1) ? OP_SPARE_A : OP_SPARE_B);
                    1: act(OP_BYTE);
                    2: act(OP_HEADER);
                    3: act(OP_CLEAR);
                    4: act(OP_ENABLE);
                    5: act(OP_DISABLE);
                    default: pop_oldest();
                endcase
            end
            else
            begin
                // Record cut short, then something that may close or supersede it
                flen = 8'($urandom_range(40, 2));
                send(OP_HEADER, 3'($urandom_range(7)), $urandom, flen,
                     8'($urandom_range(255)));
                k = $urandom_range(flen - 1);
                repeat (k) act(OP_BYTE);
                case ($urandom_range(3))
                    0: pop_oldest();
                    1: record(pick_length(), 1'b0);
                    2: act($urandom_range(1) ? OP_CLEAR : OP_ENABLE);
                    default:
                    begin
                        act(OP_DISABLE);
                        act(OP_HEADER);
                    end
                endcase
            end
        end
        calm <= 1'b0;

        // Overrun the ring, then clear while wrapped
        act(OP_ENABLE);
        repeat (FLOOD) record(8'($urandom_range(3) == 0), 1'b0);
        pop_oldest();
        pop_oldest();
        act(OP_CLEAR);
        pop_oldest();

        // Overrun again and drain it completely
        repeat (FLOOD) record(8'($urandom_range(3) == 0), 1'b0);
        while (sh_held != 0)
            pop_oldest();
        pop_oldest();

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
